[hw/rtl/cpbb_pkg.sv]
// Shared types, codes and defaults for the clipped page bitmap blitter.
`timescale 1ns / 1ps
`default_nettype none

package cpbb_pkg;

  localparam int unsigned DISPLAY_WIDTH_DEF  = 84;
  localparam int unsigned DISPLAY_HEIGHT_DEF = 48;
  localparam int unsigned DISPLAY_PAGES_DEF  = 6;
  localparam int unsigned BITMAP_BYTES_DEF   = 1024;

  // raw store address before wrapping: column plus row times width, row below 8
  localparam int unsigned RAW_ADDR_W  = 12;
  localparam int unsigned RECIP_SHIFT = 20;

  localparam logic [7:0] CMD_COLUMN = 8'h80;
  localparam logic [7:0] CMD_PAGE   = 8'h40;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_STEP  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_DATA = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_COL  = 2'd1,
    PH_PAGE = 2'd2,
    PH_DATA = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_MODQ = 2'd1,
    SEQ_MODR = 2'd2,
    SEQ_COMB = 2'd3
  } seq_e;

  // Clipped draw geometry derived from origin, width and page count.
  typedef struct packed {
    logic [7:0] xs;       // first display column
    logic [7:0] xoff;     // first bitmap column shown
    logic [8:0] end_col;  // bitmap column where the visible run stops
    logic [3:0] n_pages;  // display pages touched
    logic [4:0] yoff;     // whole pages of vertical offset
    logic [2:0] shift;    // pixel remainder of vertical offset
    logic       neg;      // origin above the display
    logic [3:0] span;     // bitmap pages that feed the draw
  } geom_t;

endpackage

`default_nettype wire

[hw/rtl/cpbb_if.sv]
// Valid/ready channel interfaces for blitter items and results.
`timescale 1ns / 1ps
`default_nettype none

interface cpbb_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [9:0]        load_index;
  logic [7:0]        load_value;
  logic signed [7:0] pos_x;
  logic signed [7:0] pos_y;
  logic [7:0]        bmp_width;
  logic [6:0]        bmp_height;

  modport source (
    output valid, action, load_index, load_value, pos_x, pos_y, bmp_width, bmp_height,
    input  ready
  );
  modport sink (
    input  valid, action, load_index, load_value, pos_x, pos_y, bmp_width, bmp_height,
    output ready
  );
endinterface

interface cpbb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] lcd_byte;
  logic       last;

  modport source (output valid, kind, lcd_byte, last, input ready);
  modport sink (input valid, kind, lcd_byte, last, output ready);
endinterface

`default_nettype wire

[hw/rtl/clipped_page_bitmap_blitter.sv]
// Top level of the clipped page bitmap blitter.
`timescale 1ns / 1ps
`default_nettype none

// Bitmap blitter for a page-addressed LCD. Action 0 writes one byte into the
// bitmap store, action 1 starts a draw at a signed position, action 2 asks for
// the next byte: per page a column cursor command, a page cursor command and
// then the visible data columns, clipped at all four display edges and shifted
// by the vertical pixel remainder. Every item returns exactly one result in
// the output register, so the next item is taken once that register is free
// and no data byte is in flight. Loads, starts, idle steps and cursor commands
// go into it directly. A data byte passes address multiply, a reciprocal
// quotient that wraps the address into the store depth, one read on the two
// read ports (both neighboring bitmap pages at once), and the shift merge.
// The store is not cleared at reset; reading a byte never loaded is undefined.

module clipped_page_bitmap_blitter #(
  parameter int unsigned DISPLAY_WIDTH  = cpbb_pkg::DISPLAY_WIDTH_DEF,
  parameter int unsigned DISPLAY_HEIGHT = cpbb_pkg::DISPLAY_HEIGHT_DEF,
  parameter int unsigned DISPLAY_PAGES  = cpbb_pkg::DISPLAY_PAGES_DEF,
  parameter int unsigned BITMAP_BYTES   = cpbb_pkg::BITMAP_BYTES_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  cpbb_in_if.sink       item_i,
  cpbb_out_if.source    result_o
);

  localparam int unsigned RawW  = cpbb_pkg::RAW_ADDR_W;
  localparam int unsigned RecSh = cpbb_pkg::RECIP_SHIFT;
  localparam int unsigned ProdW = RawW + RecSh;
  localparam int unsigned AddrW = $clog2(BITMAP_BYTES);
  localparam logic [ProdW-1:0] Recip  = ProdW'((1 << RecSh) / BITMAP_BYTES);
  localparam logic [RawW-1:0]  BytesW = RawW'(BITMAP_BYTES);
  localparam logic [10:0]      BytesL = 11'(BITMAP_BYTES);
  localparam logic [8:0]       DispW  = 9'(DISPLAY_WIDTH);
  localparam logic [8:0]       DispH  = 9'(DISPLAY_HEIGHT);

  // draw state
  logic signed [7:0] org_x_q, org_x_d;
  logic signed [7:0] org_y_q, org_y_d;
  logic [7:0]        width_q, width_d;
  logic [3:0]        pages_q, pages_d;
  logic [3:0]        page_q, page_d;
  logic [7:0]        col_q, col_d;
  cpbb_pkg::phase_e  phase_q, phase_d;
  cpbb_pkg::seq_e    seq_q, seq_d;

  // output register
  logic              out_valid_q, out_valid_d;
  cpbb_pkg::kind_e   out_kind_q, out_kind_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  // data byte pipeline
  logic [RawW-1:0]   raw_a_q, raw_a_d, raw_b_q, raw_b_d;
  logic [RawW-1:0]   quo_a_q, quo_b_q;
  logic              use_a_q, use_a_d, use_b_q, use_b_d;
  logic              neg_q, neg_d;
  logic [2:0]        shift_q, shift_d;
  logic              last_pend_q, last_pend_d;

  cpbb_pkg::geom_t   g_cur;
  cpbb_pkg::geom_t   g_new;

  logic              accept;
  logic              out_free;
  logic [6:0]        h_sat;
  logic [7:0]        h_round;
  logic [3:0]        new_pages;
  logic [9:0]        y_bottom;
  logic [9:0]        x_right;
  logic              start_ok;
  logic [3:0]        page_inc;
  logic [8:0]        col_inc;
  logic [3:0]        row_a, row_b;
  logic [RawW-1:0]   prod_a, prod_b;
  logic              step_use_a, step_use_b;
  logic [ProdW-1:0]  rp_a, rp_b;
  logic [RawW-1:0]   rem_a, rem_b;
  logic [RawW-1:0]   addr_a, addr_b;
  logic              mem_we;
  logic              mem_re;
  logic [7:0]        rdata_a, rdata_b;
  logic [7:0]        lo_byte, hi_byte;
  logic [15:0]       pair_dn, pair_up;
  logic [7:0]        merged;

  cpbb_geom #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_PAGES (DISPLAY_PAGES)
  ) u_geom_cur (
    .org_x_i (org_x_q),
    .org_y_i (org_y_q),
    .width_i (width_q),
    .pages_i (pages_q),
    .geom_o  (g_cur)
  );

  cpbb_geom #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_PAGES (DISPLAY_PAGES)
  ) u_geom_new (
    .org_x_i (item_i.pos_x),
    .org_y_i (item_i.pos_y),
    .width_i (item_i.bmp_width),
    .pages_i (new_pages),
    .geom_o  (g_new)
  );

  // start item: saturate height, round up to pages, reject draws off screen
  assign h_sat     = (item_i.bmp_height > 7'd64) ? 7'd64 : item_i.bmp_height;
  assign h_round   = {1'b0, h_sat} + 8'd7;
  assign new_pages = h_round[6:3];
  assign y_bottom  = {{2{item_i.pos_y[7]}}, item_i.pos_y} + {3'd0, h_sat};
  assign x_right   = {{2{item_i.pos_x[7]}}, item_i.pos_x} + {2'd0, item_i.bmp_width};
  assign start_ok  = !y_bottom[9] && !x_right[9]
                  && (item_i.pos_y[7] || ({1'b0, $unsigned(item_i.pos_y)} < DispH))
                  && (item_i.pos_x[7] || ({1'b0, $unsigned(item_i.pos_x)} < DispW));

  // bitmap rows feeding the current data byte
  always_comb begin
    if (g_cur.neg) begin
      row_a      = 4'({1'b0, page_q} + g_cur.yoff);
      row_b      = 4'(row_a + 4'd1);
      step_use_a = 1'b1;
      step_use_b = (g_cur.shift != 3'd0) && (4'(page_q + 4'd1) != g_cur.span);
    end else begin
      row_a      = page_q;
      row_b      = 4'(page_q - 4'd1);
      step_use_a = (page_q != g_cur.span);
      step_use_b = (g_cur.shift != 3'd0) && (page_q != 4'd0);
    end
  end

  assign prod_a = RawW'(row_a) * RawW'(width_q);
  assign prod_b = RawW'(row_b) * RawW'(width_q);

  // wrap addresses into the store depth: quotient by reciprocal, one correction
  assign rp_a   = ProdW'(raw_a_q) * Recip;
  assign rp_b   = ProdW'(raw_b_q) * Recip;
  assign rem_a  = raw_a_q - RawW'(quo_a_q * BytesW);
  assign rem_b  = raw_b_q - RawW'(quo_b_q * BytesW);
  assign addr_a = (rem_a >= BytesW) ? rem_a - BytesW : rem_a;
  assign addr_b = (rem_b >= BytesW) ? rem_b - BytesW : rem_b;

  assign out_free = !out_valid_q || result_o.ready;
  assign accept   = item_i.valid && item_i.ready;
  assign mem_we   = accept && (item_i.action == cpbb_pkg::ACT_LOAD)
                 && ({1'b0, item_i.load_index} < BytesL);
  assign mem_re   = (seq_q == cpbb_pkg::SEQ_MODR);

  // page shift merge across two neighboring bitmap pages
  assign lo_byte = use_a_q ? rdata_a : 8'd0;
  assign hi_byte = use_b_q ? rdata_b : 8'd0;
  assign pair_dn = {hi_byte, lo_byte} >> shift_q;
  assign pair_up = {lo_byte, hi_byte} << shift_q;
  assign merged  = neg_q ? pair_dn[7:0] : pair_up[15:8];

  cpbb_ram #(
    .WIDTH (8),
    .DEPTH (BITMAP_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (item_i.load_index[AddrW-1:0]),
    .wdata_i   (item_i.load_value),
    .re_i      (mem_re),
    .raddr_a_i (addr_a[AddrW-1:0]),
    .raddr_b_i (addr_b[AddrW-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign item_i.ready    = (seq_q == cpbb_pkg::SEQ_IDLE) && out_free;
  assign result_o.valid  = out_valid_q;
  assign result_o.kind   = out_kind_q;
  assign result_o.lcd_byte = out_byte_q;
  assign result_o.last   = out_last_q;

  always_comb begin
    org_x_d     = org_x_q;
    org_y_d     = org_y_q;
    width_d     = width_q;
    pages_d     = pages_q;
    page_d      = page_q;
    col_d       = col_q;
    phase_d     = phase_q;
    seq_d       = seq_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    raw_a_d     = raw_a_q;
    raw_b_d     = raw_b_q;
    use_a_d     = use_a_q;
    use_b_d     = use_b_q;
    neg_d       = neg_q;
    shift_d     = shift_q;
    last_pend_d = last_pend_q;
    page_inc    = 4'(page_q + 4'd1);
    col_inc     = {1'b0, col_q} + 9'd1;

    unique case (seq_q)
      cpbb_pkg::SEQ_IDLE: begin
        if (accept) begin
          out_kind_d = cpbb_pkg::KIND_NONE;
          out_byte_d = 8'd0;
          unique case (item_i.action)
            cpbb_pkg::ACT_START: begin
              // abandon any running draw
              org_x_d = item_i.pos_x;
              org_y_d = item_i.pos_y;
              width_d = item_i.bmp_width;
              pages_d = new_pages;
              page_d  = 4'd0;
              col_d   = 8'd0;
              phase_d = (start_ok && (g_new.n_pages != 4'd0)) ? cpbb_pkg::PH_COL
                                                              : cpbb_pkg::PH_IDLE;
            end
            cpbb_pkg::ACT_STEP: begin
              unique case (phase_q)
                cpbb_pkg::PH_COL: begin
                  out_kind_d = cpbb_pkg::KIND_CMD;
                  out_byte_d = cpbb_pkg::CMD_COLUMN + g_cur.xs;
                  phase_d    = cpbb_pkg::PH_PAGE;
                end
                cpbb_pkg::PH_PAGE: begin
                  out_kind_d = cpbb_pkg::KIND_CMD;
                  out_byte_d = cpbb_pkg::CMD_PAGE + (g_cur.neg ? {4'd0, page_q}
                               : 8'({3'd0, g_cur.yoff} + {4'd0, page_q}));
                  col_d      = g_cur.xoff;
                  if ({1'b0, g_cur.xoff} < g_cur.end_col) begin
                    phase_d = cpbb_pkg::PH_DATA;
                  end else begin
                    page_d  = page_inc;
                    phase_d = (page_inc >= g_cur.n_pages) ? cpbb_pkg::PH_IDLE
                                                          : cpbb_pkg::PH_COL;
                  end
                end
                cpbb_pkg::PH_DATA: begin
                  raw_a_d = prod_a + RawW'(col_q);
                  raw_b_d = prod_b + RawW'(col_q);
                  use_a_d = step_use_a;
                  use_b_d = step_use_b;
                  neg_d   = g_cur.neg;
                  shift_d = g_cur.shift;
                  col_d   = col_inc[7:0];
                  if (col_inc >= g_cur.end_col) begin
                    page_d  = page_inc;
                    phase_d = (page_inc >= g_cur.n_pages) ? cpbb_pkg::PH_IDLE
                                                          : cpbb_pkg::PH_COL;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase

          if ((item_i.action == cpbb_pkg::ACT_STEP) && (phase_q == cpbb_pkg::PH_DATA)) begin
            seq_d       = cpbb_pkg::SEQ_MODQ;
            last_pend_d = (phase_d == cpbb_pkg::PH_IDLE);
          end else begin
            out_valid_d = 1'b1;
            out_last_d  = (phase_d == cpbb_pkg::PH_IDLE);
          end
        end
      end
      cpbb_pkg::SEQ_MODQ: begin
        seq_d = cpbb_pkg::SEQ_MODR;
      end
      cpbb_pkg::SEQ_MODR: begin
        seq_d = cpbb_pkg::SEQ_COMB;
      end
      cpbb_pkg::SEQ_COMB: begin
        // hold the read data until the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = cpbb_pkg::KIND_DATA;
          out_byte_d  = merged;
          out_last_d  = last_pend_q;
          seq_d       = cpbb_pkg::SEQ_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q     <= 8'sd0;
      org_y_q     <= 8'sd0;
      width_q     <= 8'd0;
      pages_q     <= 4'd0;
      page_q      <= 4'd0;
      col_q       <= 8'd0;
      phase_q     <= cpbb_pkg::PH_IDLE;
      seq_q       <= cpbb_pkg::SEQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      org_x_q     <= org_x_d;
      org_y_q     <= org_y_d;
      width_q     <= width_d;
      pages_q     <= pages_d;
      page_q      <= page_d;
      col_q       <= col_d;
      phase_q     <= phase_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q  <= out_kind_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    raw_a_q     <= raw_a_d;
    raw_b_q     <= raw_b_d;
    use_a_q     <= use_a_d;
    use_b_q     <= use_b_d;
    neg_q       <= neg_d;
    shift_q     <= shift_d;
    last_pend_q <= last_pend_d;
    if (seq_q == cpbb_pkg::SEQ_MODQ) begin
      quo_a_q <= rp_a[RecSh +: RawW];
      quo_b_q <= rp_b[RecSh +: RawW];
    end
  end

  // Every item except a data step lands in the output register at once.
  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !((item_i.action == cpbb_pkg::ACT_STEP) && (phase_q == cpbb_pkg::PH_DATA))
    |=> result_o.valid)
    else $error("non-data item produced no result");

  // A data step walks the address and read stages in order.
  a_data_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.action == cpbb_pkg::ACT_STEP) && (phase_q == cpbb_pkg::PH_DATA)
    |=> (seq_q == cpbb_pkg::SEQ_MODQ) ##1 (seq_q == cpbb_pkg::SEQ_MODR)
        ##1 (seq_q == cpbb_pkg::SEQ_COMB))
    else $error("data step pipeline out of order");

  // Wrapped read addresses stay inside the store.
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == cpbb_pkg::SEQ_MODR) |-> (addr_a < BytesW) && (addr_b < BytesW))
    else $error("store read address out of range");

  // The column counter never runs past the visible run.
  a_col_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == cpbb_pkg::PH_DATA) |-> ({1'b0, col_q} < g_cur.end_col))
    else $error("column counter beyond visible run");

endmodule

`default_nettype wire

[hw/rtl/cpbb_ram.sv]
// Generic synchronous RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module cpbb_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data while no read is issued
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cpbb_geom.sv]
// Clipping geometry of a draw against the display edges.
`timescale 1ns / 1ps
`default_nettype none

module cpbb_geom #(
  parameter int unsigned DISPLAY_WIDTH = cpbb_pkg::DISPLAY_WIDTH_DEF,
  parameter int unsigned DISPLAY_PAGES = cpbb_pkg::DISPLAY_PAGES_DEF
) (
  input  wire logic signed [7:0] org_x_i,
  input  wire logic signed [7:0] org_y_i,
  input  wire logic        [7:0] width_i,
  input  wire logic        [3:0] pages_i,
  output cpbb_pkg::geom_t        geom_o
);

  localparam logic [8:0] DispW = 9'(DISPLAY_WIDTH);
  localparam logic [4:0] DispP = 5'(DISPLAY_PAGES);

  logic       x_neg;
  logic       y_neg;
  logic [7:0] y_mag;
  logic [8:0] x_lim;
  logic [4:0] y_off;
  logic [4:0] pages5;
  logic [4:0] span5;
  logic [4:0] n_raw;
  logic [4:0] p_lim;

  always_comb begin
    x_neg          = org_x_i[7];
    geom_o.xs      = x_neg ? 8'd0 : $unsigned(org_x_i);
    geom_o.xoff    = x_neg ? 8'(-org_x_i) : 8'd0;
    x_lim          = {1'b0, geom_o.xoff} + DispW - {1'b0, geom_o.xs};
    geom_o.end_col = ({1'b0, width_i} < x_lim) ? {1'b0, width_i} : x_lim;

    y_neg        = org_y_i[7];
    y_mag        = y_neg ? 8'(-org_y_i) : $unsigned(org_y_i);
    y_off        = y_mag[7:3];
    geom_o.yoff  = y_off;
    geom_o.shift = y_mag[2:0];
    geom_o.neg   = y_neg;

    pages5 = {1'b0, pages_i};
    p_lim  = (y_off < DispP) ? DispP - y_off : 5'd0;
    if (y_neg) begin
      span5 = (pages5 > y_off) ? pages5 - y_off : 5'd0;
      n_raw = (span5 < DispP) ? span5 : DispP;
    end else begin
      // a nonzero shift spills the last page into one more display page
      span5 = pages5;
      n_raw = (pages5 == 5'd0) ? 5'd0 : pages5 + {4'd0, geom_o.shift != 3'd0};
      if (n_raw > p_lim) begin
        n_raw = p_lim;
      end
    end
    geom_o.span    = span5[3:0];
    geom_o.n_pages = n_raw[3:0];
  end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the clipped page bitmap blitter.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import cpbb_pkg::*;

  localparam int          CLK_HALF    = 2;
  localparam int          RST_CYCLES  = 9;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          TAIL_CYCLES = 30;
  localparam int          RAND_ITEMS  = 180;
  localparam int          DISP_W      = int'(DISPLAY_WIDTH_DEF);
  localparam int          DISP_H      = int'(DISPLAY_HEIGHT_DEF);
  localparam int          DISP_PAGES  = int'(DISPLAY_PAGES_DEF);
  localparam int          BMP_BYTES   = int'(BITMAP_BYTES_DEF);
  // every draw below reads only from this loaded low region of the store
  localparam int          FILL_BYTES  = 144;
  localparam int          MAX_HEIGHT  = 64;
  localparam logic [1:0]  ACT_NOP     = 2'd3;

  typedef struct {
    logic [1:0]        action;
    logic [9:0]        load_index;
    logic [7:0]        load_value;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic [7:0]        bmp_width;
    logic [6:0]        bmp_height;
  } blit_item_t;

  typedef struct {
    kind_e      kind;
    logic [7:0] lcd_byte;
    logic       last;
  } lcd_out_t;

  typedef struct {
    int disp_col0;
    int bmp_col0;
    int col_end;
    int page_cnt;
    int page_off;
    int shift;
    int src_pages;
    bit above;
  } clip_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cpbb_in_if  item_if ();
  cpbb_out_if result_if ();

  clipped_page_bitmap_blitter DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // predictor state
  logic [7:0] bmp_mem [BMP_BYTES];
  logic [7:0] st_org_x, st_org_y, st_width, st_pages, st_page, st_col;
  phase_e     st_phase;

  lcd_out_t lcd_bytes_due [$];
  lcd_out_t want;
  int       fail_count  = 0;
  int       items_sent  = 0;
  int       cycle_count = 0;
  int       burst_left  = 0;

  // receiver controls
  logic hold_go   = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   rx_mode   = 0;
  int   rx_span   = 0;

  function automatic int img_at(int addr);
    return int'(bmp_mem[addr % BMP_BYTES]);
  endfunction

  function automatic clip_t clip_draw();
    clip_t g;
    int x, y, w, pages, lim, yy;
    x = int'($signed(st_org_x));
    y = int'($signed(st_org_y));
    w = int'(st_width);
    pages = int'(st_pages);
    g.disp_col0 = x < 0 ? 0 : x;
    g.bmp_col0  = x < 0 ? -x : 0;
    lim = g.bmp_col0 + DISP_W - g.disp_col0;
    g.col_end = w < lim ? w : lim;
    if (y < 0) begin
      yy = -y;
      g.above     = 1'b1;
      g.page_off  = yy / 8;
      g.shift     = yy % 8;
      g.src_pages = pages > g.page_off ? pages - g.page_off : 0;
      g.page_cnt  = g.src_pages < DISP_PAGES ? g.src_pages : DISP_PAGES;
    end else begin
      g.above     = 1'b0;
      g.page_off  = y / 8;
      g.shift     = y % 8;
      g.src_pages = pages;
      g.page_cnt  = pages == 0 ? 0 : pages + (g.shift != 0 ? 1 : 0);
      lim = g.page_off < DISP_PAGES ? DISP_PAGES - g.page_off : 0;
      if (g.page_cnt > lim) g.page_cnt = lim;
    end
    return g;
  endfunction

  // merge two neighboring bitmap pages into one display page byte
  function automatic logic [7:0] merged_byte(clip_t g, int pg, int col);
    int w, r, b;
    w = int'(st_width);
    b = 0;
    if (g.above) begin
      r = pg + g.page_off;
      b = img_at(col + r * w) >> g.shift;
      if (pg + 1 != g.src_pages && g.shift != 0)
        b = b | (img_at(col + (r + 1) * w) << (8 - g.shift));
    end else begin
      if (pg != g.src_pages) b = img_at(col + pg * w) << g.shift;
      if (pg != 0 && g.shift != 0)
        b = b | (img_at(col + (pg - 1) * w) >> (8 - g.shift));
    end
    return 8'(b);
  endfunction

  function automatic void advance_page(clip_t g);
    st_page  = 8'((int'(st_page) + 1) & 15);
    st_phase = int'(st_page) >= g.page_cnt ? PH_IDLE : PH_COL;
  endfunction

  function automatic lcd_out_t predict_lcd_byte(blit_item_t it);
    lcd_out_t o;
    clip_t    g;
    int       x, y, w, h, c, row;
    o.kind     = KIND_NONE;
    o.lcd_byte = 8'h00;
    case (it.action)
      ACT_LOAD: begin
        if (int'(it.load_index) < BMP_BYTES) bmp_mem[it.load_index] = it.load_value;
      end
      ACT_START: begin
        x = int'(it.pos_x);
        y = int'(it.pos_y);
        w = int'(it.bmp_width);
        h = int'(it.bmp_height);
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        st_org_x = it.pos_x;
        st_org_y = it.pos_y;
        st_width = it.bmp_width;
        st_pages = 8'((h + 7) / 8);
        st_page  = 8'h00;
        st_col   = 8'h00;
        st_phase = PH_IDLE;
        if (y + h >= 0 && x + w >= 0 && y < DISP_H && x < DISP_W) begin
          g = clip_draw();
          if (g.page_cnt != 0) st_phase = PH_COL;
        end
      end
      ACT_STEP: begin
        if (st_phase != PH_IDLE) begin
          g = clip_draw();
          case (st_phase)
            PH_COL: begin
              o.kind     = KIND_CMD;
              o.lcd_byte = CMD_COLUMN + 8'(g.disp_col0);
              st_phase   = PH_PAGE;
            end
            PH_PAGE: begin
              row        = g.above ? int'(st_page) : g.page_off + int'(st_page);
              o.kind     = KIND_CMD;
              o.lcd_byte = CMD_PAGE + 8'(row);
              st_col     = 8'(g.bmp_col0);
              if (g.bmp_col0 < g.col_end) st_phase = PH_DATA;
              else advance_page(g);
            end
            default: begin
              c          = int'(st_col);
              o.kind     = KIND_DATA;
              o.lcd_byte = merged_byte(g, int'(st_page), c);
              c++;
              st_col = 8'(c);
              if (c >= g.col_end) advance_page(g);
            end
          endcase
        end
      end
      default: ;
    endcase
    o.last = st_phase == PH_IDLE;
    return o;
  endfunction

  function automatic void flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic blit_item_t rand_item(logic [1:0] act);
    blit_item_t it;
    it.action     = act;
    it.load_index = 10'($urandom);
    it.load_value = 8'($urandom);
    it.pos_x      = 8'($urandom);
    it.pos_y      = 8'($urandom);
    it.bmp_width  = 8'($urandom);
    it.bmp_height = 7'($urandom);
    return it;
  endfunction

  function automatic blit_item_t start_item(int x, int y, int w, int h);
    blit_item_t it;
    it = rand_item(ACT_START);
    it.pos_x      = 8'(x);
    it.pos_y      = 8'(y);
    it.bmp_width  = 8'(w);
    it.bmp_height = 7'(h);
    return it;
  endfunction

  function automatic blit_item_t load_item(int idx, int val);
    blit_item_t it;
    it = rand_item(ACT_LOAD);
    it.load_index = 10'(idx);
    it.load_value = 8'(val);
    return it;
  endfunction

  // Entered and left in the posedge step; drive happens at the next negedge.
  task automatic send_item(blit_item_t it);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    item_if.valid      <= 1'b1;
    item_if.action     <= it.action;
    item_if.load_index <= it.load_index;
    item_if.load_value <= it.load_value;
    item_if.pos_x      <= it.pos_x;
    item_if.pos_y      <= it.pos_y;
    item_if.bmp_width  <= it.bmp_width;
    item_if.bmp_height <= it.bmp_height;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    items_sent++;
    lcd_bytes_due.push_back(predict_lcd_byte(it));
  endtask

  task automatic step_until_done();
    while (st_phase != PH_IDLE) send_item(rand_item(ACT_STEP));
  endtask

  task automatic draw(int x, int y, int w, int h);
    send_item(start_item(x, y, w, h));
    step_until_done();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (lcd_bytes_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_idle_after_reset();
    send_item(rand_item(ACT_STEP));
    send_item(rand_item(ACT_NOP));
    send_item(start_item(100, 0, 8, 8));
    send_item(rand_item(ACT_STEP));
  endtask

  task automatic test_fill_store();
    for (int i = 0; i < FILL_BYTES; i++) send_item(load_item(i, $urandom_range(0, 255)));
  endtask

  task automatic test_clipping();
    draw(0, 0, 8, 8);
    draw(3, 5, 10, 12);
    draw(-5, -3, 12, 20);
    draw(-100, 0, 128, 8);      // wide bitmap shifted far left
    draw(-128, 0, 140, 8);
    draw(80, 40, 20, 16);       // clipped at right and bottom
    draw(10, 10, 0, 16);        // cursor commands only
    draw(10, 10, 8, 0);
    draw(0, -20, 8, 127);       // height saturates
    draw(84, 0, 8, 8);
    draw(0, 48, 8, 8);
    draw(-128, 0, 100, 8);
    draw(0, -128, 8, 64);
    draw(0, -16, 8, 16);        // every source page above the display
    draw(127, 127, 255, 127);
    draw(-1, -1, 1, 1);
    draw(70, 47, 20, 64);
  endtask

  task automatic test_restart_and_reload();
    send_item(start_item(0, 0, 4, 16));
    send_item(rand_item(ACT_STEP));
    send_item(rand_item(ACT_STEP));
    send_item(load_item(2, 8'hA5));
    send_item(load_item(5, 8'h3C));
    step_until_done();
    send_item(start_item(5, 3, 20, 20));
    repeat (6) send_item(rand_item(ACT_STEP));
    draw(-3, -9, 10, 30);
  endtask

  task automatic test_output_backpressure();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    hold_go       <= ~hold_go;
    draw(2, 4, 12, 16);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int         counted, pick;
    bit         aborted;
    blit_item_t it;
    counted = 0;
    while (counted < RAND_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(load_item($urandom_range(0, BMP_BYTES - 1), $urandom_range(0, 255)));
          counted++;
        end
      end else begin
        if (pick == 2)
          it = start_item($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 16), $urandom_range(0, 127));
        else
          it = start_item(int'($urandom_range(0, 99)) - 20, int'($urandom_range(0, 59)) - 12,
                          $urandom_range(1, 20), $urandom_range(1, 24));
        send_item(it);
        counted++;
        aborted = 1'b0;
        while (st_phase != PH_IDLE && !aborted) begin
          pick = $urandom_range(0, 59);
          if (pick < 4) begin
            send_item(load_item($urandom_range(0, BMP_BYTES - 1), $urandom_range(0, 255)));
            counted++;
          end else if (pick < 6) begin
            send_item(rand_item(ACT_NOP));
          end else if (pick == 6) begin
            aborted = 1'b1;   // drop the draw; the next start abandons it
          end else begin
            send_item(rand_item(ACT_STEP));
            counted++;
          end
        end
        if ($urandom_range(0, 3) == 0) send_item(rand_item(ACT_STEP));
      end
    end
  endtask

  // receiver: long hold-off on request, else a changing stall pattern
  always @(negedge clk_i) begin
    if (hold_seen != hold_go) begin
      hold_seen       <= hold_go;
      hold_left       <= HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_span <= $urandom_range(8, 60);
      end else begin
        rx_span <= rx_span - 1;
      end
      case (rx_mode)
        0: result_if.ready <= 1'b1;
        1: result_if.ready <= ($urandom_range(0, 3) != 0);
        2: result_if.ready <= ~result_if.ready;
        default: result_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (lcd_bytes_due.size() == 0) begin
        flag_error($sformatf("unexpected result kind=%0d byte=%02h last=%0b",
                             result_if.kind, result_if.lcd_byte, result_if.last));
      end else begin
        want = lcd_bytes_due.pop_front();
        if (result_if.kind !== want.kind || result_if.lcd_byte !== want.lcd_byte ||
            result_if.last !== want.last)
          flag_error($sformatf(
            "mismatch: exp kind=%0d byte=%02h last=%0b, got kind=%0d byte=%02h last=%0b",
            want.kind, want.lcd_byte, want.last,
            result_if.kind, result_if.lcd_byte, result_if.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    item_if.valid        = 1'b0;
    item_if.action       = ACT_LOAD;
    item_if.load_index   = '0;
    item_if.load_value   = '0;
    item_if.pos_x        = '0;
    item_if.pos_y        = '0;
    item_if.bmp_width    = '0;
    item_if.bmp_height   = '0;
    result_if.ready      = 1'b0;
    st_org_x = '0;
    st_org_y = '0;
    st_width = '0;
    st_pages = '0;
    st_page  = '0;
    st_col   = '0;
    st_phase = PH_IDLE;
    for (int i = 0; i < BMP_BYTES; i++) bmp_mem[i] = '0;
    repeat (RST_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_idle_after_reset();
    test_fill_store();
    test_clipping();
    test_restart_and_reload();
    test_output_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hw/rtl/cpbb_pkg.sv
hw/rtl/cpbb_if.sv
hw/rtl/cpbb_ram.sv
hw/rtl/cpbb_geom.sv
hw/rtl/clipped_page_bitmap_blitter.sv
tb/sv/tb.sv
